[design/stick_repeat_gate_and_sector_select_defines.svh]
// Assertion macros shared by the stick repeat gate and sector select RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef STICK_REPEAT_GATE_AND_SECTOR_SELECT_DEFINES_SVH
`define STICK_REPEAT_GATE_AND_SECTOR_SELECT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SRSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SRSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/srss_pkg.sv]
// Package for the stick repeat gate and sector select block.
// Holds payload and config types, register codes, constants and helper functions.
`timescale 1ns / 1ps

package srss_pkg;

  // Config port geometry
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 7;

  // Config register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_ENTRY_COUNT        = 3'd0,
    CFG_RING_SLOTS         = 3'd1,
    CFG_HOLD_FRAMES        = 3'd2,
    CFG_THROTTLE_THRESHOLD = 3'd3,
    CFG_DEAD_ZONE          = 3'd4
  } cfg_reg_t;

  // Config reset values
  localparam logic [6:0] RST_ENTRY_COUNT        = 7'd8;
  localparam logic [6:0] RST_RING_SLOTS         = 7'd8;
  localparam logic [3:0] RST_HOLD_FRAMES        = 4'd8;
  localparam logic [6:0] RST_THROTTLE_THRESHOLD = 7'd50;
  localparam logic [6:0] RST_DEAD_ZONE          = 7'd30;

  // CORDIC datapath
  localparam int CORDIC_W   = 31;  // signed x/y width, holds 128 * 2^20 * gain
  localparam int SCALE_SH   = 20;
  localparam int ANGLE_W    = 32;  // turn accumulator
  localparam int ITER_W     = 4;
  localparam logic [ITER_W-1:0] LAST_ITER = 4'd15;
  localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

  // Hand-off queue depth
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [6:0] entry_count;
    logic [6:0] ring_slots;
    logic [3:0] hold_frames;
    logic [6:0] throttle_threshold;
    logic [6:0] dead_zone;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        controller;
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] gated_x;
    logic signed [7:0] gated_y;
    logic              sector_valid;
    logic [5:0]        sector_index;
  } out_item_t;

  // Item between front and back: gated sample plus the angle decision
  typedef struct packed {
    logic signed [7:0] gated_x;
    logic signed [7:0] gated_y;
    logic              try_angle;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Any coordinate strictly outside +-t
  function automatic logic beyond(logic signed [7:0] x, logic signed [7:0] y,
                                  logic [6:0] t);
    logic signed [8:0] tp;
    logic signed [8:0] tn;
    logic signed [8:0] xe;
    logic signed [8:0] ye;
    tp = $signed({2'b00, t});
    tn = -tp;
    xe = 9'(x);
    ye = 9'(y);
    return (xe < tn) || (xe > tp) || (ye < tn) || (ye > tp);
  endfunction

  // Both coordinates strictly inside +-t
  function automatic logic inside_box(logic signed [7:0] x, logic signed [7:0] y,
                                      logic [6:0] t);
    logic signed [8:0] tp;
    logic signed [8:0] tn;
    logic signed [8:0] xe;
    logic signed [8:0] ye;
    tp = $signed({2'b00, t});
    tn = -tp;
    xe = 9'(x);
    ye = 9'(y);
    return (xe > tn) && (xe < tp) && (ye > tn) && (ye < tp);
  endfunction

  // atan(2^-i) as a fraction of a turn, scaled by 2^32
  function automatic logic [ANGLE_W-1:0] atan_turn(logic [ITER_W-1:0] i);
    logic [ANGLE_W-1:0] a;
    unique case (i)
      4'd0:    a = 32'd536870912;
      4'd1:    a = 32'd316933406;
      4'd2:    a = 32'd167458907;
      4'd3:    a = 32'd85004756;
      4'd4:    a = 32'd42667331;
      4'd5:    a = 32'd21354465;
      4'd6:    a = 32'd10679838;
      4'd7:    a = 32'd5340245;
      4'd8:    a = 32'd2670163;
      4'd9:    a = 32'd1335087;
      4'd10:   a = 32'd667544;
      4'd11:   a = 32'd333772;
      4'd12:   a = 32'd166886;
      4'd13:   a = 32'd83443;
      4'd14:   a = 32'd41722;
      default: a = 32'd20861;
    endcase
    return a;
  endfunction

endpackage

[design/stick_repeat_gate_and_sector_select.sv]
// Top level of the stick repeat gate and sector select block: config registers,
// gating front, hand-off queue and CORDIC back end. Depends on srss_pkg.
//
//   channel  | direction | handshake             | payload
//   in_      | input     | in_valid / in_stall   | in_data  (controller, stick_x, stick_y)
//   out_     | output    | out_valid / out_stall | out_data (gated_x, gated_y, sector)
//   cfg_     | input     | cfg_we                | cfg_index, cfg_wdata
//
// An item needing an angle passes through the back end as one load, 16 CORDIC
// steps on one shared shift/add unit, one multiply, one reduce, one output load.
// Items with no angle (inside the dead zone or unusable counts) go from load straight to output load.
// Synchronous active-low reset clears hold counters, queue and output, and
// restores config defaults. The two-entry queue keeps accepting items while the
// back end works; out_stall holds the output register and in_stall means full.
`timescale 1ns / 1ps

module stick_repeat_gate_and_sector_select #(
  parameter int CONTROLLERS = 4,
  parameter int MAX_SECTORS = 64,
  parameter int ANGLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  srss_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output srss_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [srss_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [srss_pkg::CFG_DW-1:0]   cfg_wdata
);

  srss_pkg::cfg_t    cfg_r, cfg_nxt;
  logic              push;
  logic              pop;
  srss_pkg::q_item_t push_item;
  srss_pkg::q_item_t head;
  srss_pkg::q_stat_t q_stat;

  // Config write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        srss_pkg::CFG_ENTRY_COUNT:        cfg_nxt.entry_count        = cfg_wdata[6:0];
        srss_pkg::CFG_RING_SLOTS:         cfg_nxt.ring_slots         = cfg_wdata[6:0];
        srss_pkg::CFG_HOLD_FRAMES:        cfg_nxt.hold_frames        = cfg_wdata[3:0];
        srss_pkg::CFG_THROTTLE_THRESHOLD: cfg_nxt.throttle_threshold = cfg_wdata[6:0];
        srss_pkg::CFG_DEAD_ZONE:          cfg_nxt.dead_zone          = cfg_wdata[6:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entry_count        <= srss_pkg::RST_ENTRY_COUNT;
      cfg_r.ring_slots         <= srss_pkg::RST_RING_SLOTS;
      cfg_r.hold_frames        <= srss_pkg::RST_HOLD_FRAMES;
      cfg_r.throttle_threshold <= srss_pkg::RST_THROTTLE_THRESHOLD;
      cfg_r.dead_zone          <= srss_pkg::RST_DEAD_ZONE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  srss_front #(
    .CONTROLLERS (CONTROLLERS),
    .MAX_SECTORS (MAX_SECTORS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  srss_queue #(
    .DEPTH (srss_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  srss_back #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[design/srss_front.sv]
// Front end: accepts stick items, applies per-controller repeat gating and
// decides whether an angle is needed. Depends on srss_pkg.
`timescale 1ns / 1ps

module srss_front #(
  parameter int CONTROLLERS = 4,
  parameter int MAX_SECTORS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  srss_pkg::in_item_t in_data,
  input  srss_pkg::cfg_t     cfg,
  input  srss_pkg::q_stat_t  q_stat,
  output logic               push,
  output srss_pkg::q_item_t  push_item
);

  logic [3:0] hold_r   [CONTROLLERS];
  logic [3:0] hold_nxt [CONTROLLERS];

  logic                   accept;
  logic                   ctl_ok;
  logic [CONTROLLERS-1:0] sel;
  logic [3:0]             hc;
  logic [3:0]             hc_new;
  logic signed [7:0]      gx;
  logic signed [7:0]      gy;
  logic                   cnt_ok;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // Counter lookup for this item's controller
  always_comb begin
    ctl_ok = int'(in_data.controller) < CONTROLLERS;
    hc     = '0;
    for (int c = 0; c < CONTROLLERS; c++) begin
      sel[c] = ctl_ok && (int'(in_data.controller) == c);
      hc     = hc | (sel[c] ? hold_r[c] : 4'd0);
    end
  end

  // Repeat gate
  always_comb begin
    gx     = in_data.stick_x;
    gy     = in_data.stick_y;
    hc_new = hc;
    if (ctl_ok) begin
      if (hc != 4'd0) begin
        if (srss_pkg::inside_box(in_data.stick_x, in_data.stick_y,
                                 cfg.throttle_threshold)) begin
          hc_new = 4'd0;
        end else begin
          hc_new = hc - 4'd1;
          gx     = '0;
          gy     = '0;
        end
      end else if (srss_pkg::beyond(in_data.stick_x, in_data.stick_y,
                                    cfg.throttle_threshold)) begin
        hc_new = cfg.hold_frames;
      end
    end
    for (int c = 0; c < CONTROLLERS; c++) begin
      hold_nxt[c] = (accept && sel[c]) ? hc_new : hold_r[c];
    end
  end

  // Sector counts usable at all
  assign cnt_ok = (cfg.entry_count != 7'd0) && (cfg.ring_slots != 7'd0) &&
                  (cfg.ring_slots >= cfg.entry_count) &&
                  (int'(cfg.ring_slots) <= MAX_SECTORS);

  always_comb begin
    push                = accept;
    push_item.gated_x   = gx;
    push_item.gated_y   = gy;
    push_item.try_angle = cnt_ok && srss_pkg::beyond(gx, gy, cfg.dead_zone);
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < CONTROLLERS; c++) begin
      if (!rst_n) begin
        hold_r[c] <= '0;
      end else begin
        hold_r[c] <= hold_nxt[c];
      end
    end
  end

endmodule

[design/srss_queue.sv]
// Short FIFO that decouples the gating front from the angle back end.
// Depends on srss_pkg for the item and status types.
`timescale 1ns / 1ps

module srss_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  srss_pkg::q_item_t push_item,
  input  logic              pop,
  output srss_pkg::q_item_t head,
  output srss_pkg::q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  srss_pkg::q_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = cnt_r == CW'(DEPTH);
  assign stat.empty = cnt_r == '0;

  // Pointer wrap and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[design/srss_back.sv]
// Back end: iterative CORDIC arctangent, sector scaling and output register.
// Depends on srss_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "stick_repeat_gate_and_sector_select_defines.svh"

module srss_back #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  srss_pkg::cfg_t      cfg,
  input  srss_pkg::q_stat_t   q_stat,
  input  srss_pkg::q_item_t   head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output srss_pkg::out_item_t out_data
);

  localparam int CW = srss_pkg::CORDIC_W;
  localparam int AW = srss_pkg::ANGLE_W;
  localparam int PW = ANGLE_BITS + 8;
  localparam logic [ANGLE_BITS-1:0] ROT_NORTH = ANGLE_BITS'(3) << (ANGLE_BITS - 2);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ITER = 5'b00010,
    S_MUL  = 5'b00100,
    S_MOD  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [srss_pkg::ITER_W-1:0]     it_r, it_nxt;
  logic signed [CW-1:0]            x_r, x_nxt;
  logic signed [CW-1:0]            y_r, y_nxt;
  logic [AW-1:0]                   th_r, th_nxt;
  logic [PW-1:0]                   prod_r, prod_nxt;
  logic signed [7:0]               gx_r, gx_nxt;
  logic signed [7:0]               gy_r, gy_nxt;
  logic                            sec_valid_r, sec_valid_nxt;
  logic [5:0]                      sec_r, sec_nxt;
  logic                            out_valid_r, out_valid_nxt;
  srss_pkg::out_item_t             out_data_r, out_data_nxt;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic signed [8:0]       xi;
    logic signed [8:0]       yi;
    logic signed [CW-1:0]    dx;
    logic signed [CW-1:0]    dy;
    logic [AW-1:0]           atn;
    logic [ANGLE_BITS-1:0]   u;
    logic [6:0]              diff;
    logic [6:0]              k;
    logic [PW-1:0]           sum;
    logic [6:0]              q;
    logic [6:0]              r;

    state_nxt     = state_r;
    it_nxt        = it_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    th_nxt        = th_r;
    prod_nxt      = prod_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    sec_valid_nxt = sec_valid_r;
    sec_nxt       = sec_r;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;

    xi   = 9'(head.gated_x);
    yi   = 9'(head.gated_y);
    dx   = y_r >>> it_r;
    dy   = x_r >>> it_r;
    atn  = srss_pkg::atan_turn(it_r);
    u    = th_r[AW-1 -: ANGLE_BITS] + ROT_NORTH;
    diff = cfg.ring_slots - cfg.entry_count;
    k    = (diff == 7'd0) ? 7'd0 : (diff[0] ? cfg.entry_count : cfg.entry_count - 7'd1);
    sum  = prod_r + (PW'(k) << ANGLE_BITS);
    q    = sum[PW-1 -: 7];
    r    = (q >= cfg.ring_slots) ? q - cfg.ring_slots : q;

    // Output register drains independently of the work in progress
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop    = 1'b1;
          gx_nxt = head.gated_x;
          gy_nxt = head.gated_y;
          if (head.try_angle) begin
            // Left half-plane: pre-rotate by half a turn
            if (xi < 0) begin
              xi     = -xi;
              yi     = -yi;
              th_nxt = srss_pkg::HALF_TURN;
            end else begin
              th_nxt = '0;
            end
            x_nxt     = CW'(xi) <<< srss_pkg::SCALE_SH;
            y_nxt     = CW'(yi) <<< srss_pkg::SCALE_SH;
            it_nxt    = '0;
            state_nxt = S_ITER;
          end else begin
            sec_valid_nxt = 1'b0;
            sec_nxt       = '0;
            state_nxt     = S_DONE;
          end
        end
      end
      // One vectoring step per cycle
      S_ITER: begin
        if (!y_r[CW-1]) begin
          x_nxt  = x_r + dx;
          y_nxt  = y_r - dy;
          th_nxt = th_r + atn;
        end else begin
          x_nxt  = x_r - dx;
          y_nxt  = y_r + dy;
          th_nxt = th_r - atn;
        end
        it_nxt = it_r + 1'b1;
        if (it_r == srss_pkg::LAST_ITER) begin
          state_nxt = S_MUL;
        end
      end
      // 2*u*V
      S_MUL: begin
        prod_nxt  = PW'({u, 1'b0}) * PW'(cfg.ring_slots);
        state_nxt = S_MOD;
      end
      // Offset, scale down, reduce mod V (quotient stays below 2V)
      S_MOD: begin
        if ((diff != 7'd0) && (r >= cfg.entry_count)) begin
          sec_valid_nxt = 1'b0;
          sec_nxt       = '0;
        end else begin
          sec_valid_nxt = 1'b1;
          sec_nxt       = r[5:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.gated_x      = gx_r;
          out_data_nxt.gated_y      = gy_r;
          out_data_nxt.sector_valid = sec_valid_r;
          out_data_nxt.sector_index = sec_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk) begin
    it_r        <= it_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    th_r        <= th_nxt;
    prod_r      <= prod_nxt;
    gx_r        <= gx_nxt;
    gy_r        <= gy_nxt;
    sec_valid_r <= sec_valid_nxt;
    sec_r       <= sec_nxt;
    out_data_r  <= out_data_nxt;
  end

  // x only grows during vectoring and never wraps
  `SRSS_ASSERT_SAME(a_cordic_x_pos, clk, rst_n, state_r == S_ITER, !x_r[CW-1], "CORDIC x went negative")
  // Multiply follows exactly the last rotation step
  `SRSS_ASSERT_NEXT(a_mul_after_iter, clk, rst_n, (state_r == S_ITER) && (it_r == srss_pkg::LAST_ITER), state_r == S_MUL, "multiply did not follow last CORDIC step")
  // Rejected sectors carry index zero
  `SRSS_ASSERT_SAME(a_sector_zero, clk, rst_n, state_r == S_DONE, sec_valid_r || (sec_r == '0), "invalid sector with nonzero index")

endmodule

[tb/sv/stick_sector_checker.sv]
// Output checker for the stick repeat gate and sector select block.
// Mirrors config writes and hold counters, predicts each output item, compares.
// Depends on srss_pkg for payload types, register codes and reset values.
`timescale 1ns / 1ps

module stick_sector_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  srss_pkg::in_item_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  srss_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [srss_pkg::CFG_IW-1:0] cfg_index,
  input  logic [srss_pkg::CFG_DW-1:0] cfg_wdata,
  output int                          mismatches,
  output int                          outstanding,
  output int                          compared
);

  localparam int NUM_CTL      = 4;
  localparam int SECTOR_LIMIT = 64;
  localparam int THETA_W      = 16;

  // atan(2^-i) in turns, scaled by 2^32
  logic [31:0] atan_lut [16] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  // Shadow registers and per-controller hold counters
  logic [6:0] cards_q;
  logic [6:0] vcards_q;
  logic [3:0] hold_len_q;
  logic [6:0] thr_q;
  logic [6:0] dz_q;
  logic [3:0] hold_cnt [NUM_CTL];

  srss_pkg::out_item_t gate_q [$];
  int                  err_cnt;
  int                  done_cnt;

  function automatic logic outside_box(int x, int y, int t);
    return (x < -t) || (x > t) || (y < -t) || (y > t);
  endfunction

  // Vectoring CORDIC, angle as an unsigned fraction of a turn
  function automatic logic [31:0] turn_angle(int ax, int ay);
    longint      px;
    longint      py;
    longint      sx;
    longint      sy;
    logic [31:0] acc;
    acc = '0;
    px  = ax;
    py  = ay;
    if (px < 0) begin
      px  = -px;
      py  = -py;
      acc = 32'h8000_0000;
    end
    px = px * 1048576;
    py = py * 1048576;
    for (int i = 0; i < 16; i++) begin
      sx = py >>> i;
      sy = px >>> i;
      if (py >= 0) begin
        px  = px + sx;
        py  = py - sy;
        acc = acc + atan_lut[i];
      end else begin
        px  = px - sx;
        py  = py + sy;
        acc = acc - atan_lut[i];
      end
    end
    return acc;
  endfunction

  // Gate one sample (updates its hold counter) and pick its sector
  function automatic srss_pkg::out_item_t gate_and_sector(srss_pkg::in_item_t s);
    srss_pkg::out_item_t r;
    int                  x;
    int                  y;
    int                  t;
    int                  c;
    int                  v;
    int                  diff;
    longint              u;
    longint              k;
    longint              sec;
    logic [1:0]          ctl;
    x   = s.stick_x;
    y   = s.stick_y;
    t   = int'(thr_q);
    ctl = s.controller;
    if (hold_cnt[ctl] != 4'd0) begin
      if (x > -t && x < t && y > -t && y < t) begin
        hold_cnt[ctl] = 4'd0;
      end else begin
        hold_cnt[ctl] = hold_cnt[ctl] - 4'd1;
        x = 0;
        y = 0;
      end
    end else if (outside_box(x, y, t)) begin
      hold_cnt[ctl] = hold_len_q;
    end
    r.gated_x      = x[7:0];
    r.gated_y      = y[7:0];
    r.sector_valid = 1'b0;
    r.sector_index = '0;
    c = int'(cards_q);
    v = int'(vcards_q);
    if (outside_box(x, y, int'(dz_q)) && c != 0 && v != 0 && v >= c &&
        v <= SECTOR_LIMIT) begin
      // rotate so north is zero, then scale onto the virtual circle
      u    = (longint'(turn_angle(x, y) >> (32 - THETA_W)) +
              (longint'(3) << (THETA_W - 2))) & ((longint'(1) << THETA_W) - 1);
      diff = v - c;
      k    = 0;
      if (diff != 0) k = diff[0] ? c : c - 1;
      sec = ((2 * u * v + (k << THETA_W)) >> (THETA_W + 1)) % v;
      if (!(diff != 0 && sec >= c)) begin
        r.sector_valid = 1'b1;
        r.sector_index = sec[5:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    srss_pkg::out_item_t want;
    if (!rst_n) begin
      cards_q    <= srss_pkg::RST_ENTRY_COUNT;
      vcards_q   <= srss_pkg::RST_RING_SLOTS;
      hold_len_q <= srss_pkg::RST_HOLD_FRAMES;
      thr_q      <= srss_pkg::RST_THROTTLE_THRESHOLD;
      dz_q       <= srss_pkg::RST_DEAD_ZONE;
      for (int i = 0; i < NUM_CTL; i++) hold_cnt[i] = 4'd0;
      gate_q.delete();
      err_cnt  = 0;
      done_cnt = 0;
    end else begin
      // register writes, unmapped indexes ignored
      if (cfg_we) begin
        case (cfg_index)
          srss_pkg::CFG_ENTRY_COUNT:        cards_q    <= cfg_wdata;
          srss_pkg::CFG_RING_SLOTS:         vcards_q   <= cfg_wdata;
          srss_pkg::CFG_HOLD_FRAMES:        hold_len_q <= cfg_wdata[3:0];
          srss_pkg::CFG_THROTTLE_THRESHOLD: thr_q      <= cfg_wdata;
          srss_pkg::CFG_DEAD_ZONE:          dz_q       <= cfg_wdata;
          default: ;
        endcase
      end
      // compare before queuing, so a result never matches its own input edge
      if (out_valid && !out_stall) begin
        if (gate_q.size() == 0) begin
          $display("%t unexpected output item x=%0d y=%0d valid=%0b sector=%0d", $time,
                   out_data.gated_x, out_data.gated_y, out_data.sector_valid,
                   out_data.sector_index);
          err_cnt++;
        end else begin
          want = gate_q.pop_front();
          done_cnt++;
          if (out_data.gated_x !== want.gated_x || out_data.gated_y !== want.gated_y ||
              out_data.sector_valid !== want.sector_valid ||
              out_data.sector_index !== want.sector_index) begin
            $display("%t mismatch: expected x=%0d y=%0d valid=%0b sector=%0d, got x=%0d y=%0d valid=%0b sector=%0d",
                     $time, want.gated_x, want.gated_y, want.sector_valid,
                     want.sector_index, out_data.gated_x, out_data.gated_y,
                     out_data.sector_valid, out_data.sector_index);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) gate_q.push_back(gate_and_sector(in_data));
    end
    mismatches  <= err_cnt;
    outstanding <= gate_q.size();
    compared    <= done_cnt;
  end

endmodule

[tb/sv/testbench.sv]
// Top of the stick repeat gate and sector select testbench: clock, reset, stimulus.
// Drives stick samples and register settings; stick_sector_checker does the checking.
// Depends on srss_pkg, stick_sector_checker and the block itself.
`timescale 1ns / 1ps

module testbench;

  localparam int         NUM_SETS     = 10;
  localparam int         SET_ITEMS    = 138;
  localparam int         DRAIN_CYCLES = 30;
  localparam int         QUIET_LIMIT  = 3000;
  localparam logic [2:0] UNMAPPED_REG = 3'd7;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  srss_pkg::in_item_t          in_data;
  logic                        out_valid;
  logic                        out_stall;
  srss_pkg::out_item_t         out_data;
  logic                        cfg_we;
  logic [srss_pkg::CFG_IW-1:0] cfg_index;
  logic [srss_pkg::CFG_DW-1:0] cfg_wdata;

  int mismatches;
  int outstanding;
  int compared;
  int send_gap_pct;
  int stall_pct;
  int sent;
  int quiet;
  int cur_thr;
  int cur_dz;

  stick_repeat_gate_and_sector_select DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  stick_sector_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver back-pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic signed [7:0] clamp8(int v);
    if (v > 127) return 8'sd127;
    if (v < -128) return -8'sd128;
    return v[7:0];
  endfunction

  // Coordinate on or next to the throttle or dead-zone bound
  function automatic logic signed [7:0] bound_coord(int thr, int dz);
    int v;
    v = ($urandom_range(1) ? thr : dz) + int'($urandom_range(2)) - 1;
    if ($urandom_range(1)) v = -v;
    return clamp8(v);
  endfunction

  function automatic srss_pkg::in_item_t make_sample(int thr, int dz, logic [1:0] ctl);
    srss_pkg::in_item_t s;
    int                 kind;
    int                 lim;
    int                 mag;
    logic signed [7:0]  far;
    s.controller = ctl;
    kind         = $urandom_range(99);
    if (kind < 30) begin
      s.stick_x = 8'($urandom);
      s.stick_y = 8'($urandom);
    end else if (kind < 55) begin
      s.stick_x = bound_coord(thr, dz);
      s.stick_y = $urandom_range(1) ? bound_coord(thr, dz) : clamp8(int'($urandom_range(20)) - 10);
    end else if (kind < 75) begin
      // well inside the throttle box, clears a held controller
      lim       = (thr > 0) ? thr - 1 : 0;
      s.stick_x = clamp8(int'($urandom_range(2 * lim)) - lim);
      s.stick_y = clamp8(int'($urandom_range(2 * lim)) - lim);
    end else begin
      // hard push past the threshold on one axis
      mag = int'($urandom_range(128, (thr + 1 > 128) ? 128 : thr + 1));
      far = clamp8($urandom_range(1) ? -mag : mag);
      if ($urandom_range(1)) begin
        s.stick_x = far;
        s.stick_y = 8'($urandom);
      end else begin
        s.stick_x = 8'($urandom);
        s.stick_y = far;
      end
    end
    return s;
  endfunction

  task automatic send_sample(input srss_pkg::in_item_t s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct && gap < 60) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Wait until every output item has come back, then let the block settle
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  // Register settings: extremes, odd and even virtual padding, too-small,
  // zero and oversize circles
  task automatic load_setting(input int n);
    logic [6:0] cc;
    logic [6:0] vc;
    logic [6:0] hf;
    logic [6:0] tt;
    logic [6:0] dz;
    case (n)
      0:       {cc, vc, hf, tt, dz} = {7'd8,  7'd8,   7'd8,  7'd50,  7'd30};
      1:       {cc, vc, hf, tt, dz} = {7'd1,  7'd1,   7'd0,  7'd0,   7'd0};
      2:       {cc, vc, hf, tt, dz} = {7'd64, 7'd64,  7'd15, 7'd127, 7'd127};
      3:       {cc, vc, hf, tt, dz} = {7'd5,  7'd8,   7'd3,  7'd40,  7'd10};
      4:       {cc, vc, hf, tt, dz} = {7'd6,  7'd10,  7'd4,  7'd60,  7'd20};
      5:       {cc, vc, hf, tt, dz} = {7'd10, 7'd4,   7'd2,  7'd30,  7'd5};
      6:       {cc, vc, hf, tt, dz} = {7'd0,  7'd0,   7'd7,  7'd20,  7'd15};
      7:       {cc, vc, hf, tt, dz} = {7'd12, 7'd100, 7'd89, 7'd70,  7'd25};
      8:       {cc, vc, hf, tt, dz} = {7'd1,  7'd64,  7'd15, 7'd90,  7'd1};
      default: {cc, vc, hf, tt, dz} = {7'd63, 7'd64,  7'd1,  7'd10,  7'd0};
    endcase
    put_reg(srss_pkg::CFG_ENTRY_COUNT, cc);
    put_reg(srss_pkg::CFG_RING_SLOTS, vc);
    put_reg(srss_pkg::CFG_HOLD_FRAMES, hf);
    put_reg(srss_pkg::CFG_THROTTLE_THRESHOLD, tt);
    put_reg(srss_pkg::CFG_DEAD_ZONE, dz);
    put_reg(UNMAPPED_REG, 7'($urandom));
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_thr = int'(tt);
    cur_dz  = int'(dz);
  endtask

  initial begin
    srss_pkg::in_item_t s;
    logic [1:0]         ctl;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = srss_pkg::CFG_ENTRY_COUNT;
    cfg_wdata    = '0;
    send_gap_pct = 11;
    stall_pct    = 81;
    sent         = 0;
    cur_thr      = int'(srss_pkg::RST_THROTTLE_THRESHOLD);
    cur_dz       = int'(srss_pkg::RST_DEAD_ZONE);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed samples at reset settings: zero vector, hold, bound equality,
    // clear from inside, compass points and full-scale corners
    send_sample('{2'd0, 8'sd0, 8'sd0});
    send_sample('{2'd0, 8'sd127, 8'sd0});
    send_sample('{2'd0, 8'sd127, 8'sd0});
    send_sample('{2'd0, 8'sd50, 8'sd50});
    send_sample('{2'd0, 8'sd49, -8'sd49});
    send_sample('{2'd0, 8'sd31, 8'sd0});
    send_sample('{2'd0, 8'sd30, -8'sd30});
    send_sample('{2'd0, -8'sd31, 8'sd31});
    send_sample('{2'd1, -8'sd128, -8'sd128});
    send_sample('{2'd1, -8'sd128, 8'sd127});
    send_sample('{2'd1, 8'sd0, 8'sd0});
    send_sample('{2'd1, 8'sd127, -8'sd128});
    send_sample('{2'd2, 8'sd0, 8'sd127});
    send_sample('{2'd2, 8'sd0, -8'sd128});
    send_sample('{2'd2, -8'sd50, 8'sd0});
    send_sample('{2'd2, -8'sd49, 8'sd1});
    send_sample('{2'd3, -8'sd128, 8'sd0});
    send_sample('{2'd3, 8'sd127, 8'sd127});
    send_sample('{2'd3, -8'sd51, 8'sd0});
    send_sample('{2'd3, 8'sd51, -8'sd51});
    send_sample('{2'd3, 8'sd0, 8'sd0});
    send_sample('{2'd0, -8'sd1, -8'sd128});
    drain_block();

    // Random samples under each register setting; controllers mostly in bursts
    ctl = 2'd0;
    for (int n = 0; n < NUM_SETS; n++) begin
      if (n == 4) begin
        send_gap_pct = 81;
        stall_pct    = 11;
      end else if (n == 7) begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      load_setting(n);
      for (int i = 0; i < SET_ITEMS; i++) begin
        if ($urandom_range(99) < 30) ctl = 2'($urandom_range(3));
        s = make_sample(cur_thr, cur_dz, ctl);
        send_sample(s);
      end
      drain_block();
    end

    $display("Sent %0d stick samples across %0d register settings, %0d outputs compared.",
             sent, NUM_SETS + 1, compared);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
